@@ hdl/nrf_pkg.sv @@
// Shared types and constants for the nonce replay filter.
// No dependencies; used by nrf_ctrl, nrf_datapath and nonce_replay_filter.
`default_nettype none
package nrf_pkg;

   // Register indexes on the configuration port
   localparam logic CSR_ENTRY_LIMIT = 1'b0;
   localparam logic CSR_LIFETIME    = 1'b1;

   localparam logic [8:0]  LIMIT_RESET    = 9'd256;
   localparam logic [63:0] LIFETIME_RESET = 64'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EVICT_CMP,
      ST_EVICT_RD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic record_tick;
      logic rd_scan;
      logic pop;
      logic scan_init;
      logic scan_adv;
      logic insert;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic time_ok;
      logic evict_hit;
      logic scan_done;
      logic scan_match;
      logic room;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

@@ hdl/nrf_ctrl.sv @@
// Controller state machine for the nonce replay filter.
// Depends on nrf_pkg; drives commands to nrf_datapath.
`default_nettype none
module nrf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire nrf_pkg::status_type status,
   output nrf_pkg::cmd_type        cmd
);

   nrf_pkg::state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nrf_pkg::ST_IDLE: begin
            if (req_valid) state_in = nrf_pkg::ST_CHECK;
         end
         nrf_pkg::ST_CHECK: begin
            state_in = status.time_ok ? nrf_pkg::ST_EVICT_CMP : nrf_pkg::ST_FINISH;
         end
         nrf_pkg::ST_EVICT_CMP: begin
            state_in = status.evict_hit ? nrf_pkg::ST_EVICT_RD : nrf_pkg::ST_SCAN_RD;
         end
         nrf_pkg::ST_EVICT_RD: begin
            state_in = nrf_pkg::ST_EVICT_CMP;
         end
         nrf_pkg::ST_SCAN_RD: begin
            state_in = status.scan_done ? nrf_pkg::ST_FINISH : nrf_pkg::ST_SCAN_CMP;
         end
         nrf_pkg::ST_SCAN_CMP: begin
            state_in = status.scan_match ? nrf_pkg::ST_FINISH : nrf_pkg::ST_SCAN_RD;
         end
         nrf_pkg::ST_FINISH: begin
            if (status.rsp_free) state_in = nrf_pkg::ST_IDLE;
         end
         default: state_in = nrf_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         nrf_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         nrf_pkg::ST_CHECK: begin
            cmd.record_tick = status.time_ok;
         end
         nrf_pkg::ST_EVICT_CMP: begin
            cmd.pop       = status.evict_hit;
            cmd.scan_init = !status.evict_hit;
         end
         nrf_pkg::ST_EVICT_RD: begin
         end
         nrf_pkg::ST_SCAN_RD: begin
            cmd.rd_scan = !status.scan_done;
            cmd.insert  = status.scan_done && status.room;
         end
         nrf_pkg::ST_SCAN_CMP: begin
            cmd.scan_adv = !status.scan_match;
         end
         nrf_pkg::ST_FINISH: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/nrf_datapath.sv @@
// Datapath of the nonce replay filter: entry memory, FIFO pointers,
// configuration registers and result register. Depends on nrf_pkg.
`default_nettype none
module nrf_datapath #(
   parameter int CAPACITY   = 256,
   parameter int NONCE_BITS = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   input  wire logic               csr_index,
   input  wire logic [63:0]        csr_data,
   input  wire logic [63:0]        req_nonce_low,
   input  wire logic [63:0]        req_nonce_high,
   input  wire logic [63:0]        req_now_tick,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_verdict,
   output logic [8:0]              rsp_occupancy,
   input  wire nrf_pkg::cmd_type   cmd,
   output nrf_pkg::status_type     status
);

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = ((CNT_W > 9) ? CNT_W : 9) + 1;
   localparam int ENTRY_W = NONCE_BITS + 64;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
   localparam logic [CMP_W-1:0] CAP_CMP   = CMP_W'(CAPACITY);

   logic [ENTRY_W-1:0]    store_mem [CAPACITY];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;

   logic [8:0]            limit_ff;
   logic [63:0]           lifetime_ff;
   logic [NONCE_BITS-1:0] key_ff;
   logic [63:0]           now_ff;
   logic [63:0]           prev_tick_ff;
   logic                  tick_seen_ff;
   logic [IDX_W-1:0]      head_ff, tail_ff, slot_ff;
   logic [CNT_W-1:0]      count_ff, scan_k_ff;
   logic                  verdict_ff;
   logic                  rsp_valid_ff, rsp_verdict_ff;
   logic [8:0]            rsp_occ_ff;

   logic [127:0]          nonce_full;
   logic [63:0]           ttl;
   logic [64:0]           expiry_sum;
   logic [CMP_W-1:0]      lim_eff, count_cmp;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   assign nonce_full = {req_nonce_high, req_nonce_low};
   assign ttl        = (lifetime_ff == 64'd0) ? 64'd1 : lifetime_ff;
   assign expiry_sum = {1'b0, now_ff} + {1'b0, ttl};

   // Clamp the entry limit to one..capacity
   always_comb begin
      lim_eff = CMP_W'(limit_ff);
      if (lim_eff == '0) lim_eff = CMP_W'(1);
      if (lim_eff > CAP_CMP) lim_eff = CAP_CMP;
   end
   assign count_cmp = CMP_W'(count_ff);

   // Status back to the controller
   assign status.time_ok    = !(tick_seen_ff && (now_ff < prev_tick_ff)) && !expiry_sum[64];
   assign status.evict_hit  = (count_ff != '0) && (rd_data_ff[63:0] <= now_ff);
   assign status.scan_done  = (scan_k_ff == count_ff);
   assign status.scan_match = (rd_data_ff[ENTRY_W-1:64] == key_ff);
   assign status.room       = (count_cmp < lim_eff);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Entry memory: one write, one registered read
   assign rd_addr = cmd.rd_scan ? slot_ff : head_ff;
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         store_mem[tail_ff] <= {key_ff, expiry_sum[63:0]};
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= nrf_pkg::LIMIT_RESET;
         lifetime_ff <= nrf_pkg::LIFETIME_RESET;
      end else if (csr_valid) begin
         if (csr_index == nrf_pkg::CSR_ENTRY_LIMIT) limit_ff <= csr_data[8:0];
         if (csr_index == nrf_pkg::CSR_LIFETIME) lifetime_ff <= csr_data;
      end
   end

   // Capture the request item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= nonce_full[NONCE_BITS-1:0];
         now_ff <= req_now_tick;
      end
   end

   // FIFO pointers, count, time record and scan cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         prev_tick_ff <= '0;
         tick_seen_ff <= 1'b0;
         slot_ff      <= '0;
         scan_k_ff    <= '0;
         verdict_ff   <= 1'b1;
      end else begin
         if (cmd.capture) verdict_ff <= 1'b1;
         if (cmd.record_tick) begin
            prev_tick_ff <= now_ff;
            tick_seen_ff <= 1'b1;
         end
         if (cmd.pop) begin
            head_ff  <= next_slot(head_ff);
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.scan_init) begin
            slot_ff   <= head_ff;
            scan_k_ff <= '0;
         end
         if (cmd.scan_adv) begin
            slot_ff   <= next_slot(slot_ff);
            scan_k_ff <= scan_k_ff + 1'b1;
         end
         if (cmd.insert) begin
            tail_ff    <= next_slot(tail_ff);
            count_ff   <= count_ff + 1'b1;
            verdict_ff <= 1'b0;
         end
      end
   end

   // Result register: hold while stalled, load when the controller finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_occ_ff     <= 9'(count_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule
`default_nettype wire

@@ hdl/nonce_replay_filter.sv @@
// Nonce replay filter: one item in flight. The eviction and match loops walk the
// one-read-port entry memory; a time rejection skips both loops and a match ends the
// walk early. Result sits in an output register. A new item is taken only after the
// previous result is loaded, and a result waiting under stall holds the block.
// Synchronous active-high reset clears pointers, count, time record and config;
// the entry memory is not cleared and needs no clearing pass.
`default_nettype none
module nonce_replay_filter #(
   parameter int CAPACITY   = 256,
   parameter int NONCE_BITS = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_nonce_low,
   input  wire logic [63:0] req_nonce_high,
   input  wire logic [63:0] req_now_tick,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_verdict,
   output logic [8:0]       rsp_occupancy
);

   nrf_pkg::cmd_type    cmd;
   nrf_pkg::status_type status;

   assign csr_ready = 1'b1;

   nrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nrf_datapath #(
      .CAPACITY   (CAPACITY),
      .NONCE_BITS (NONCE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_nonce_low  (req_nonce_low),
      .req_nonce_high (req_nonce_high),
      .req_now_tick   (req_now_tick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_verdict    (rsp_verdict),
      .rsp_occupancy  (rsp_occupancy),
      .cmd            (cmd),
      .status         (status)
   );

   // One item at a time: an accepted item blocks the next
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous item in progress");

   // An accepted nonce leaves at least one held
   a_accept_occupied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_verdict && (CAPACITY < 512)) |-> (rsp_occupancy != 9'd0))
      else $error("accepted item reports empty table");

   // Occupancy never passes capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((CAPACITY >= 512) || (rsp_occupancy <= 9'(CAPACITY))))
      else $error("occupancy above capacity");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for nonce_replay_filter: directed table then random phases.
// Depends on hdl/nrf_pkg.sv and hdl/nonce_replay_filter.sv; predicts every verdict itself.
`default_nettype none
module tb_top;

   typedef enum logic [1:0] {ROW_REQ, ROW_LIMIT, ROW_LIFE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [63:0]  now;
      logic         typed;
      logic         verdict;
      logic [8:0]   occ;
   } row_type;

   typedef struct packed {
      logic       verdict;
      logic [8:0] occ;
   } verdict_type;

   localparam int          CAP  = 256;
   localparam int          PRED_DEPTH = 16;
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid, csr_index;
   logic [63:0] csr_data;
   logic        csr_ready;
   logic        req_valid, req_stall;
   logic [63:0] req_nonce_low, req_nonce_high, req_now_tick;
   logic        rsp_valid, rsp_stall, rsp_verdict;
   logic [8:0]  rsp_occupancy;

   // predictor copy of the filter state
   logic [63:0] held_lo [CAP];
   logic [63:0] held_hi [CAP];
   logic [63:0] held_exp [CAP];
   int          head, tail, held;
   logic [63:0] last_tick;
   logic        tick_seen;
   logic [8:0]  limit_reg;
   logic [63:0] life_reg;

   // predictions waiting for their result, oldest at pred_rd
   verdict_type pred_fifo [PRED_DEPTH];
   int          pred_wr, pred_rd;
   int          errors, sent, accepted_cnt, peak;
   int          send_pct, stall_pct;
   logic [63:0] tick_ctr;
   logic [127:0] recent [8];

   nonce_replay_filter u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_nonce_low(req_nonce_low), .req_nonce_high(req_nonce_high),
      .req_now_tick(req_now_tick),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_verdict(rsp_verdict), .rsp_occupancy(rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // end the run if the block hangs
   initial begin
      #60_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // compare each delivered item with the oldest prediction
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pred_wr == pred_rd) begin
            $error("unexpected result: verdict %0d occupancy %0d", rsp_verdict, rsp_occupancy);
            errors++;
         end else begin
            want = pred_fifo[pred_rd % PRED_DEPTH];
            pred_rd++;
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_verdict);
               errors++;
            end
            if (rsp_occupancy !== want.occ) begin
               $error("occupancy: expected %0d, got %0d", want.occ, rsp_occupancy);
               errors++;
            end
         end
      end
   end

   // work out verdict and occupancy for one admission request
   task automatic admit_request(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] now, output verdict_type res);
      logic [63:0] ttl;
      int          lim, slot;
      logic        found;
      ttl = (life_reg == 0) ? 64'd1 : life_reg;
      lim = (limit_reg == 0) ? 1 : ((limit_reg > CAP) ? CAP : int'(limit_reg));
      res.verdict = 1'b1;
      if (!((tick_seen && now < last_tick) || now > ONES - ttl)) begin
         tick_seen = 1'b1;
         last_tick = now;
         while (held > 0 && held_exp[head] <= now) begin
            head = (head + 1) % CAP;
            held--;
         end
         found = 1'b0;
         slot  = head;
         for (int k = 0; k < held; k++) begin
            if (held_lo[slot] == lo && held_hi[slot] == hi) found = 1'b1;
            slot = (slot + 1) % CAP;
         end
         if (!found && held < lim) begin
            held_lo[tail]  = lo;
            held_hi[tail]  = hi;
            held_exp[tail] = now + ttl;
            tail = (tail + 1) % CAP;
            held++;
            res.verdict = 1'b0;
         end
      end
      res.occ = held[8:0];
   endtask

   // offer one item, hold it until accepted, queue its prediction
   task automatic send_item(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] now, output verdict_type res);
      if ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_nonce_low  <= lo;
      req_nonce_high <= hi;
      req_now_tick   <= now;
      do @(posedge clock); while (req_stall);
      admit_request(lo, hi, now, res);
      pred_fifo[pred_wr % PRED_DEPTH] = res;
      pred_wr++;
      sent++;
      if (!res.verdict) accepted_cnt++;
      if (res.occ > peak) peak = res.occ;
   endtask

   // wait for every result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pred_wr != pred_rd) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [63:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == nrf_pkg::CSR_ENTRY_LIMIT) limit_reg = val[8:0];
      else life_reg = val;
      @(posedge clock);
   endtask

   row_type     dir_rows[$];
   int          ph_limit[7] = '{4, 0, 511, 300, 1, 256, 16};
   longint      ph_life[7]  = '{8, 3, 20, 100000, 1, 0, 40};
   int          ph_items[7] = '{250, 200, 250, 290, 150, 150, 60};

   initial begin
      verdict_type res;
      logic [63:0] lo, hi, now;
      logic [127:0] pick;
      int           n;
      reset <= 1'b1;
      csr_valid <= 1'b0; csr_index <= 1'b0; csr_data <= '0;
      req_valid <= 1'b0; req_nonce_low <= '0; req_nonce_high <= '0; req_now_tick <= '0;
      head = 0; tail = 0; held = 0; last_tick = '0; tick_seen = 1'b0;
      limit_reg = nrf_pkg::LIMIT_RESET; life_reg = nrf_pkg::LIFETIME_RESET;
      pred_wr = 0; pred_rd = 0;
      errors = 0; sent = 0; accepted_cnt = 0; peak = 0;
      send_pct = 9; stall_pct = 65;
      for (int i = 0; i < 8; i++) recent[i] = '0;

      // directed rows: replay, expiry, backwards time, overflow, limits
      dir_rows = '{
         '{ROW_REQ,   0,    0,    0, 1, 0, 1},  // first request accepted
         '{ROW_REQ,   0,    0,    0, 1, 1, 1},  // replay while held
         '{ROW_REQ,   0,    0,    1, 1, 0, 1},  // expired, admitted again
         '{ROW_REQ,   ONES, ONES, 1, 1, 0, 2},
         '{ROW_REQ,   5,    0,    0, 1, 1, 2},  // time went backwards
         '{ROW_REQ,   ONES, ONES, 2, 1, 0, 1},
         '{ROW_LIFE,  0,    ONES, 0, 0, 0, 0},
         '{ROW_REQ,   1,    2,    2, 1, 1, 1},  // expiry would overflow
         '{ROW_LIFE,  0,    0,    0, 0, 0, 0},  // lifetime of zero
         '{ROW_REQ,   1,    2,    3, 1, 0, 1},
         '{ROW_REQ,   1,    2,    3, 1, 1, 1},
         '{ROW_LIMIT, 0,    0,    0, 0, 0, 0},  // limit of zero acts as one
         '{ROW_REQ,   7,    0,    3, 1, 1, 1},
         '{ROW_LIMIT, 0,    511,  0, 0, 0, 0},  // limit above capacity
         '{ROW_REQ,   7,    0,    3, 0, 0, 0},
         '{ROW_REQ,   8,    ONES, 3, 0, 0, 0},
         '{ROW_REQ,   ONES, 0,    4, 0, 0, 0},
         '{ROW_REQ,   7,    0,    4, 0, 0, 0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         case (dir_rows[i].kind)
            ROW_LIMIT: write_reg(nrf_pkg::CSR_ENTRY_LIMIT, dir_rows[i].hi);
            ROW_LIFE:  write_reg(nrf_pkg::CSR_LIFETIME, dir_rows[i].hi);
            default: begin
               send_item(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].now, res);
               if (dir_rows[i].typed && res.verdict !== dir_rows[i].verdict) begin
                  $error("row %0d verdict: expected %0d, predicted %0d", i,
                         dir_rows[i].verdict, res.verdict);
                  errors++;
               end
               if (dir_rows[i].typed && res.occ !== dir_rows[i].occ) begin
                  $error("row %0d occupancy: expected %0d, predicted %0d", i,
                         dir_rows[i].occ, res.occ);
                  errors++;
               end
            end
         endcase
      end
      tick_ctr = 4;

      // random phases; each phase reconfigures, then jumps time to flush old entries
      n = 0;
      for (int p = 0; p < 7; p++) begin
         write_reg(nrf_pkg::CSR_ENTRY_LIMIT, 64'(ph_limit[p]));
         write_reg(nrf_pkg::CSR_LIFETIME, 64'(ph_life[p]));
         tick_ctr += 200000;
         for (int i = 0; i < ph_items[p]; i++) begin
            case (n * 3 / 1350)
               0:       begin send_pct = 9;  stall_pct = 65; end
               1:       begin send_pct = 65; stall_pct = 9;  end
               default: begin send_pct = 0;  stall_pct = 0;  end
            endcase
            n++;
            // replay a recent nonce often, otherwise a fresh one
            if ($urandom_range(0, 99) < 40) pick = recent[$urandom_range(0, 7)];
            else pick = {$urandom, $urandom, $urandom, $urandom};
            recent[$urandom_range(0, 7)] = pick;
            lo = pick[63:0];
            hi = pick[127:64];
            if ($urandom_range(0, 99) < 5) now = tick_ctr - $urandom_range(1, 4);
            else begin
               tick_ctr += $urandom_range(0, 3);
               now = tick_ctr;
            end
            send_item(lo, hi, now, res);
         end
      end

      // top of the time range: last admissible tick, then overflow
      write_reg(nrf_pkg::CSR_LIFETIME, 64'd1);
      send_item(ONES, ONES, ONES - 64'd1, res);
      send_item(64'd0, 64'd0, ONES, res);

      drain();
      $display("Ran %0d requests: %0d admitted, %0d refused, peak occupancy %0d.",
               sent, accepted_cnt, sent - accepted_cnt, peak);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
hdl/nrf_pkg.sv
hdl/nrf_ctrl.sv
hdl/nrf_datapath.sv
hdl/nonce_replay_filter.sv
dv/tb_top.sv
